@@ src/sitr_pkg.sv @@
// ----------------------------------------------------------------------------
// sitr_pkg: shared definitions for the integer to ASCII text converter
// Widths, character codes, radix limits and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sitr_pkg;

    // Default width of the signed value taken on the input stream
    localparam int VALUE_WIDTH_DEF = 32;

    // Field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    // Quotient bits settled by the divider in one cycle
    localparam int BITS_PER_STEP = 8;

    // Radix register reset value and the range that is used for conversion
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // Character codes
    localparam logic [CHAR_W-1:0]  CH_ZERO          = 8'd48;
    localparam logic [CHAR_W-1:0]  CH_MINUS         = 8'd45;
    localparam logic [CHAR_W-1:0]  CH_LETTER_OFFSET = 8'd55;
    localparam logic [CHAR_W-1:0]  CH_TERMINATOR    = 8'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX    = 4'd9;

    // Which character the output register loads
    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_SIGN  = 2'd1,
        OUT_DIGIT = 2'd2,
        OUT_TERM  = 2'd3
    } t_out_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;         // take a new value, start the first digit
        logic     div_step;     // settle one group of quotient bits
        logic     store_digit;  // write the remainder, start the next digit
        logic     read_digit;   // read the next stored digit, count down
        t_out_sel out_sel;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic step_last;  // the current division step is the final one
        logic quot_zero;  // the quotient left after a digit is zero
        logic negative;   // the value being converted is negative
        logic cnt_zero;   // no stored digit is left to read
        logic slot_free;  // the output register can take a character
    } t_sts;

    // Digit value to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d <= DIGIT_DEC_MAX) begin
            digit_to_char = wide + CH_ZERO;
        end else begin
            digit_to_char = wide + CH_LETTER_OFFSET;
        end
    endfunction

endpackage

@@ src/signed_integer_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_radix: signed integer to ASCII text, base 2 to 16
// Converts one signed value per input item into a run of characters.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream s_axis carries one signed two's complement value per item.
//   The output stream m_axis carries one ASCII character per item, most
//   significant first: '-' for a negative value, the digits ('0'-'9', 'A'-'F'),
//   then a zero terminator with m_axis_tlast high. Zero gives "0" and the
//   terminator. The radix register is written through i_cfg_we/i_cfg_radix
//   while the block is idle; values below 2 act as 2, above 16 as 16.
//   Values are converted one at a time. For each digit the divider settles 8
//   quotient bits per cycle over the whole magnitude, then the remainder is
//   stored; each character is read from the digit store and then emitted.
//   s_axis_tready is high only between conversions.
//   Reset (synchronous, active low) sets the radix to 10 and empties the
//   output register. When the receiver stalls, the current character waits
//   in the output register and the conversion pauses until it is taken.
// ----------------------------------------------------------------------------
module signed_integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = sitr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sitr_pkg::RADIX_W-1:0]           i_cfg_radix,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: value (bits VALUE_WIDTH-1:0), zero padding above
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: char_code (bits 7:0)
    output logic [sitr_pkg::CHAR_W-1:0]            m_axis_tdata,
    output logic                                   m_axis_tlast
);
    import sitr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    sitr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Divider, digit store and output register
    sitr_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_radix (i_cfg_radix),
        .i_value     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

@@ src/sitr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sitr_ctrl: conversion sequencer
// Walks each value through digit extraction, then emits the sign, the stored
// digits from the most significant down, and the terminator.
// ----------------------------------------------------------------------------
module sitr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sitr_pkg::t_sts i_sts,
    output sitr_pkg::t_cmd o_cmd
);
    import sitr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_STORE = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_TERM  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store_digit = 1'b1;
                n_state = i_sts.quot_zero ? S_SIGN : S_DIV;
            end
            S_SIGN: begin
                if (!i_sts.negative) begin
                    n_state = S_READ;
                end else if (i_sts.slot_free) begin
                    o_cmd.out_sel = OUT_SIGN;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_digit = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_sel = OUT_DIGIT;
                    n_state       = i_sts.cnt_zero ? S_TERM : S_READ;
                end
            end
            S_TERM: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_sel = OUT_TERM;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/sitr_dp.sv @@
// ----------------------------------------------------------------------------
// sitr_dp: conversion datapath
// Holds the radix register, the magnitude with an in-place radix divider that
// settles several quotient bits a cycle, the digit store and the output
// register.
// ----------------------------------------------------------------------------
module sitr_dp #(
    parameter int VALUE_WIDTH = sitr_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sitr_pkg::RADIX_W-1:0] i_cfg_radix,
    input  logic [VALUE_WIDTH-1:0]       i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [sitr_pkg::CHAR_W-1:0]  o_out_char,
    output logic                         o_out_last,
    input  sitr_pkg::t_cmd               i_cmd,
    output sitr_pkg::t_sts               o_sts
);
    import sitr_pkg::*;

    localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W  = STEPS * BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W  = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

    logic [RADIX_W-1:0]     r_radix;
    logic [RADIX_W-1:0]     r_base;
    logic                   r_negative;
    logic [PAD_W-1:0]       r_mag;
    logic [PAD_W-1:0]       n_mag;
    logic [DIGIT_W-1:0]     r_rem;
    logic [DIGIT_W-1:0]     n_rem;
    logic [STEP_W-1:0]      r_step;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       cnt_dec;
    logic [DIGIT_W-1:0]     r_rd_digit;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;
    logic [VALUE_WIDTH-1:0] abs_value;
    logic [RADIX_W-1:0]     eff_radix;
    logic [PAD_W+BITS_PER_STEP-1:0] shifted;
    logic [BITS_PER_STEP-1:0]       qbits;

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

    // Radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_radix;
        end
    end

    // Clamp the radix into the supported range
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // Magnitude of the incoming value; the most negative value maps to itself
    // read as unsigned, which is its exact magnitude.
    assign abs_value = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    // One divider step: shift the top group of magnitude bits into the
    // remainder, producing one quotient bit each, quotient bits fill from below.
    always_comb begin
        logic [RADIX_W-1:0]       rem_v;
        logic [RADIX_W-1:0]       trial;
        logic [BITS_PER_STEP-1:0] top_bits;
        top_bits = r_mag[PAD_W-1 -: BITS_PER_STEP];
        rem_v    = {1'b0, r_rem};
        qbits    = '0;
        for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
            trial = {rem_v[DIGIT_W-1:0], top_bits[k]};
            if (trial >= r_base) begin
                rem_v    = trial - r_base;
                qbits[k] = 1'b1;
            end else begin
                rem_v = trial;
            end
        end
        n_rem   = rem_v[DIGIT_W-1:0];
        shifted = {r_mag, qbits};
        n_mag   = shifted[PAD_W-1:0];
    end

    assign cnt_dec = r_cnt - 1'b1;

    // Magnitude, remainder, step and digit count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag      <= '0;
            r_rem      <= '0;
            r_step     <= '0;
            r_cnt      <= '0;
            r_negative <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mag      <= PAD_W'(abs_value);
                r_rem      <= '0;
                r_step     <= '0;
                r_cnt      <= '0;
                r_negative <= i_value[VALUE_WIDTH-1];
            end else if (i_cmd.div_step) begin
                r_mag  <= n_mag;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
            end else if (i_cmd.store_digit) begin
                r_rem  <= '0;
                r_step <= '0;
                r_cnt  <= r_cnt + 1'b1;
            end else if (i_cmd.read_digit) begin
                r_cnt  <= cnt_dec;
            end
        end
    end

    // Base is latched per conversion
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= eff_radix;
        end
    end

    // Digit store: least significant digit at the lowest address
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_digit) begin
            digit_mem[r_cnt[IDX_W-1:0]] <= r_rem;
        end
        if (i_cmd.read_digit) begin
            r_rd_digit <= digit_mem[cnt_dec[IDX_W-1:0]];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sel != OUT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.out_sel)
            OUT_SIGN: begin
                r_out_char <= CH_MINUS;
                r_out_last <= 1'b0;
            end
            OUT_DIGIT: begin
                r_out_char <= digit_to_char(r_rd_digit);
                r_out_last <= 1'b0;
            end
            OUT_TERM: begin
                r_out_char <= CH_TERMINATOR;
                r_out_last <= 1'b1;
            end
            default: begin
                r_out_char <= r_out_char;
                r_out_last <= r_out_last;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    // Status to the controller
    assign o_sts.step_last = (r_step == STEP_W'(STEPS - 1));
    assign o_sts.quot_zero = (r_mag == '0);
    assign o_sts.negative  = r_negative;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

endmodule
